### src/cpm_pkg.sv
// Shared constants, bus types and case codes for the circle pair merge datapath.
package cpm_pkg;

    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int PICK_W    = 16;

    // square root cells: one result bit per cell
    localparam int SQ_RAD_W  = 68;
    localparam int SQ_ROOT_W = 34;
    localparam int SQ_REM_W  = 37;
    localparam int SQ_STEPS  = 34;

    // division cells: one quotient bit per cell, three lanes sharing one divisor
    localparam int DIV_NUM_W = 64;
    localparam int DIV_Q_W   = 33;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_REM_W = 35;
    localparam int DIV_LANES = 3;
    localparam int DIV_STEPS = 33;

    typedef enum logic [1:0] {
        CASE_FIRST    = 2'd0,
        CASE_SECOND   = 2'd1,
        CASE_DISJOINT = 2'd2,
        CASE_CROSS    = 2'd3
    } case_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [RAD_W-1:0]          r1;
        logic [RAD_W-1:0]          r2;
        logic [PICK_W-1:0]         frac;
        logic [COORD_W:0]          ax;
        logic [COORD_W:0]          ay;
        logic                      sx;
        logic                      sy;
    } front_side_t;

    typedef struct packed {
        case_t                code;
        logic [COORD_W-1:0]   mx;
        logic [COORD_W-1:0]   my;
        logic [RAD_W-1:0]     rsel;
        logic [RAD_W-1:0]     overlap;
        logic [PICK_W-1:0]    frac;
    } back_side_t;

    localparam int SIDE_W = $bits(front_side_t);
    localparam int BACK_W = $bits(back_side_t);

    typedef struct packed {
        logic                  valid;
        logic [SQ_RAD_W-1:0]   rad;
        logic [SQ_REM_W-1:0]   rem;
        logic [SQ_ROOT_W-1:0]  root;
        logic [SIDE_W-1:0]     side;
    } sq_bus_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [RAD_W-1:0]          r1;
        logic [RAD_W-1:0]          r2;
        logic [DIV_DEN_W-1:0]      d;
        logic [PICK_W-1:0]         frac;
        logic                      contained;
        logic                      first_small;
        logic [DIV_LANES-1:0]      neg;
    } div_side_t;

    typedef struct packed {
        logic                                  valid;
        logic [DIV_LANES-1:0][DIV_NUM_W-1:0]   num;
        logic [DIV_LANES-1:0][DIV_REM_W-1:0]   rem;
        logic [DIV_LANES-1:0][DIV_Q_W-1:0]     q;
        div_side_t                             side;
    } div_bus_t;

endpackage

### src/cpm_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cycle while en is high.
module cpm_sqrt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  cpm_pkg::sq_bus_t din,
    output cpm_pkg::sq_bus_t dout
);
    import cpm_pkg::*;

    sq_bus_t               data_reg;
    sq_bus_t               data_next;
    logic                  valid_reg;
    logic [SQ_REM_W-1:0]   rem_sh;
    logic [SQ_REM_W-1:0]   trial;

    always_comb
    begin
        rem_sh    = {din.rem[SQ_REM_W-3:0], din.rad[SQ_RAD_W-1 -: 2]};
        trial     = {1'b0, din.root, 2'b01};
        data_next = din;
        data_next.rad = din.rad << 2;
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {din.root[SQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {din.root[SQ_ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

### src/cpm_div_cell.sv
// One cell of the division chain: one quotient bit per lane per cycle while en is high.
module cpm_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cpm_pkg::div_bus_t din,
    output cpm_pkg::div_bus_t dout
);
    import cpm_pkg::*;

    div_bus_t               data_reg;
    div_bus_t               data_next;
    logic                   valid_reg;
    logic [DIV_REM_W-1:0]   den;
    logic [DIV_REM_W-1:0]   rem_sh;

    always_comb
    begin
        den       = {1'b0, din.side.d};
        rem_sh    = '0;
        data_next = din;
        for (int l = 0; l < DIV_LANES; l++)
        begin
            rem_sh = {din.rem[l][DIV_REM_W-2:0], din.num[l][DIV_NUM_W-1]};
            data_next.num[l] = din.num[l] << 1;
            if (rem_sh >= den)
            begin
                data_next.rem[l] = rem_sh - den;
                data_next.q[l]   = {din.q[l][DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem[l] = rem_sh;
                data_next.q[l]   = {din.q[l][DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

### src/circle_pair_merge_unit.sv
// Throughput: one circle pair per cycle while the pipe advances; the square root
// and division chains are rows of one-bit cells, so every cell holds a different pair.
// The whole pipe advances together; it holds while the output register is full
// and m_tready is low.
// Reset: rst_n clears every valid bit at once; data registers are not reset.
module circle_pair_merge_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_radius, second_x, second_y, second_radius,
    // pick_fraction, 2 zero bits
    input  logic [207:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // merged_x, merged_y, merged_radius, 1 zero bit
    output logic [95:0]  m_tdata,
    // case_code
    output logic [1:0]   m_tuser
);
    import cpm_pkg::*;

    // global advance: move everything unless a result sits unread
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- input unpack ----------------
    logic signed [COORD_W-1:0] in_x1, in_y1, in_x2, in_y2;
    logic [RAD_W-1:0]          in_r1, in_r2;
    logic [PICK_W-1:0]         in_frac;
    logic signed [COORD_W:0]   in_dx, in_dy;

    assign in_x1   = s_tdata[31:0];
    assign in_y1   = s_tdata[63:32];
    assign in_r1   = s_tdata[94:64];
    assign in_x2   = s_tdata[126:95];
    assign in_y2   = s_tdata[158:127];
    assign in_r2   = s_tdata[189:159];
    assign in_frac = s_tdata[205:190];
    assign in_dx   = (COORD_W+1)'(in_x2) - (COORD_W+1)'(in_x1);
    assign in_dy   = (COORD_W+1)'(in_y2) - (COORD_W+1)'(in_y1);

    // ---------------- stage 1: center deltas ----------------
    logic        s1_valid_reg;
    front_side_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.x1   <= in_x1;
            s1_reg.y1   <= in_y1;
            s1_reg.x2   <= in_x2;
            s1_reg.y2   <= in_y2;
            s1_reg.r1   <= in_r1;
            s1_reg.r2   <= in_r2;
            s1_reg.frac <= in_frac;
            s1_reg.sx   <= in_dx[COORD_W];
            s1_reg.sy   <= in_dy[COORD_W];
            s1_reg.ax   <= in_dx[COORD_W] ? ((COORD_W+1)'(0) - in_dx) : in_dx;
            s1_reg.ay   <= in_dy[COORD_W] ? ((COORD_W+1)'(0) - in_dy) : in_dy;
        end
    end

    // ---------------- stage 2: squares ----------------
    logic        s2_valid_reg;
    front_side_t s2_reg;
    logic [65:0] s2_sqx_reg, s2_sqy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg     <= s1_reg;
            s2_sqx_reg <= 66'(s1_reg.ax) * 66'(s1_reg.ax);
            s2_sqy_reg <= 66'(s1_reg.ay) * 66'(s1_reg.ay);
        end
    end

    // ---------------- distance root chain ----------------
    sq_bus_t sq1_bus [SQ_STEPS+1];

    always_comb
    begin
        sq1_bus[0].valid = s2_valid_reg;
        sq1_bus[0].rad   = SQ_RAD_W'(s2_sqx_reg) + SQ_RAD_W'(s2_sqy_reg);
        sq1_bus[0].rem   = '0;
        sq1_bus[0].root  = '0;
        sq1_bus[0].side  = s2_reg;
    end

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sq1
        cpm_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (sq1_bus[g]),
            .dout (sq1_bus[g+1])
        );
    end

    // ---------------- stage 4: containment test and products ----------------
    front_side_t          c1_side;
    logic [DIV_DEN_W-1:0] c1_d;
    logic                 c1_first_small;
    logic [RAD_W-1:0]     c1_rmin, c1_rmax, c1_rdm;
    logic [COORD_W-1:0]   c1_sum;

    assign c1_side        = front_side_t'(sq1_bus[SQ_STEPS].side);
    assign c1_d           = sq1_bus[SQ_STEPS].root;
    assign c1_first_small = c1_side.r1 < c1_side.r2;
    assign c1_rmin        = c1_first_small ? c1_side.r1 : c1_side.r2;
    assign c1_rmax        = c1_first_small ? c1_side.r2 : c1_side.r1;
    assign c1_rdm         = c1_rmax - c1_rmin;
    assign c1_sum         = COORD_W'(c1_side.r1) + COORD_W'(c1_side.r2);

    logic                                s4_valid_reg;
    logic [DIV_LANES-1:0][DIV_NUM_W-1:0] s4_prod_reg;
    div_side_t                           s4_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // lanes: center x, center y, chord offset
            s4_prod_reg[0] <= DIV_NUM_W'(c1_side.ax) * DIV_NUM_W'(c1_rdm);
            s4_prod_reg[1] <= DIV_NUM_W'(c1_side.ay) * DIV_NUM_W'(c1_rdm);
            s4_prod_reg[2] <= DIV_NUM_W'(c1_rdm) * DIV_NUM_W'(c1_sum);
            s4_side_reg.x1          <= c1_side.x1;
            s4_side_reg.y1          <= c1_side.y1;
            s4_side_reg.x2          <= c1_side.x2;
            s4_side_reg.y2          <= c1_side.y2;
            s4_side_reg.r1          <= c1_side.r1;
            s4_side_reg.r2          <= c1_side.r2;
            s4_side_reg.d           <= c1_d;
            s4_side_reg.frac        <= c1_side.frac;
            s4_side_reg.contained   <= (35'(c1_d) + 35'(c1_rmin)) <= 35'(c1_rmax);
            s4_side_reg.first_small <= c1_first_small;
            s4_side_reg.neg[0]      <= c1_side.sx ^ c1_first_small;
            s4_side_reg.neg[1]      <= c1_side.sy ^ c1_first_small;
            s4_side_reg.neg[2]      <= c1_first_small;
        end
    end

    // ---------------- rounded division chain ----------------
    // Outside containment d exceeds |r1-r2|, so every quotient fits 33 bits
    // and the top numerator bits start below the divisor.
    div_bus_t             dv_bus [DIV_STEPS+1];
    logic [DIV_NUM_W-1:0] dv_num [DIV_LANES];

    always_comb
    begin
        dv_bus[0].valid = s4_valid_reg;
        dv_bus[0].side  = s4_side_reg;
        for (int l = 0; l < DIV_LANES; l++)
        begin
            dv_num[l]         = s4_prod_reg[l] + DIV_NUM_W'(s4_side_reg.d >> 1);
            dv_bus[0].rem[l]  = DIV_REM_W'(dv_num[l][DIV_NUM_W-1:DIV_Q_W]);
            dv_bus[0].num[l]  = {dv_num[l][DIV_Q_W-1:0], (DIV_NUM_W-DIV_Q_W)'(0)};
            dv_bus[0].q[l]    = '0;
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        cpm_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (dv_bus[g]),
            .dout (dv_bus[g+1])
        );
    end

    // ---------------- stage 5: centers, case, chord offset ----------------
    div_side_t              ds;
    logic signed [34:0]     qs_x, qs_y, qs_t, sum_x, sum_y, a_val;
    logic signed [33:0]     half_x, half_y;
    logic [COORD_W-1:0]     sat_x, sat_y;
    logic [34:0]            a_mag;
    logic [COORD_W-1:0]     r_sum;
    logic [COORD_W-1:0]     two_r1;
    logic                   disjoint;
    case_t                  code_c;

    always_comb
    begin
        ds     = dv_bus[DIV_STEPS].side;
        qs_x   = ds.neg[0] ? -$signed(35'(dv_bus[DIV_STEPS].q[0]))
                           : $signed(35'(dv_bus[DIV_STEPS].q[0]));
        qs_y   = ds.neg[1] ? -$signed(35'(dv_bus[DIV_STEPS].q[1]))
                           : $signed(35'(dv_bus[DIV_STEPS].q[1]));
        qs_t   = ds.neg[2] ? -$signed(35'(dv_bus[DIV_STEPS].q[2]))
                           : $signed(35'(dv_bus[DIV_STEPS].q[2]));
        sum_x  = 35'($signed(ds.x1)) + 35'($signed(ds.x2)) + qs_x;
        sum_y  = 35'($signed(ds.y1)) + 35'($signed(ds.y2)) + qs_y;
        half_x = 34'(sum_x >>> 1);
        half_y = 34'(sum_y >>> 1);
        // saturate the floored midpoint to the coordinate range
        if (half_x[33:31] == 3'b000 || half_x[33:31] == 3'b111)
            sat_x = half_x[31:0];
        else
            sat_x = half_x[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (half_y[33:31] == 3'b000 || half_y[33:31] == 3'b111)
            sat_y = half_y[31:0];
        else
            sat_y = half_y[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        a_val    = qs_t + $signed(35'(ds.d));
        a_mag    = a_val[34] ? 35'(-a_val) : 35'(a_val);
        r_sum    = COORD_W'(ds.r1) + COORD_W'(ds.r2);
        two_r1   = {ds.r1, 1'b0};
        disjoint = 34'(ds.d) >= 34'(r_sum);
        if (ds.contained)
            code_c = ds.first_small ? CASE_FIRST : CASE_SECOND;
        else if (disjoint)
            code_c = CASE_DISJOINT;
        else
            code_c = CASE_CROSS;
    end

    logic               s5_valid_reg;
    back_side_t         s5_reg;
    logic               s5_hpos_reg;
    logic [COORD_W-1:0] s5_two_r1_reg;
    logic [COORD_W-1:0] s5_amag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg.code    <= code_c;
            s5_reg.mx      <= ds.contained ? (ds.first_small ? ds.x1 : ds.x2) : sat_x;
            s5_reg.my      <= ds.contained ? (ds.first_small ? ds.y1 : ds.y2) : sat_y;
            s5_reg.rsel    <= ds.first_small ? ds.r1 : ds.r2;
            s5_reg.overlap <= RAD_W'((34'(r_sum) - 34'(ds.d)) >> 1);
            s5_reg.frac    <= ds.frac;
            s5_hpos_reg    <= a_mag < 35'(two_r1);
            s5_two_r1_reg  <= two_r1;
            s5_amag_reg    <= a_mag[COORD_W-1:0];
        end
    end

    // ---------------- stage 6: chord squares ----------------
    logic        s6_valid_reg;
    back_side_t  s6_reg;
    logic        s6_hpos_reg;
    logic [63:0] s6_sqr_reg, s6_sqa_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_reg      <= s5_reg;
            s6_hpos_reg <= s5_hpos_reg;
            s6_sqr_reg  <= 64'(s5_two_r1_reg) * 64'(s5_two_r1_reg);
            s6_sqa_reg  <= 64'(s5_amag_reg) * 64'(s5_amag_reg);
        end
    end

    // ---------------- chord root chain ----------------
    sq_bus_t sq2_bus [SQ_STEPS+1];

    always_comb
    begin
        sq2_bus[0].valid = s6_valid_reg;
        sq2_bus[0].rad   = s6_hpos_reg ? SQ_RAD_W'(s6_sqr_reg - s6_sqa_reg) : '0;
        sq2_bus[0].rem   = '0;
        sq2_bus[0].root  = '0;
        sq2_bus[0].side  = SIDE_W'(s6_reg);
    end

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sq2
        cpm_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (sq2_bus[g]),
            .dout (sq2_bus[g+1])
        );
    end

    // ---------------- stage 7: pick within the range ----------------
    back_side_t         c2_side;
    logic [COORD_W-1:0] half_chord;

    assign c2_side    = back_side_t'(sq2_bus[SQ_STEPS].side[BACK_W-1:0]);
    assign half_chord = sq2_bus[SQ_STEPS].root[COORD_W:1];

    logic        s7_valid_reg;
    back_side_t  s7_reg;
    logic        s7_hgt_reg;
    logic [47:0] s7_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_reg      <= c2_side;
            s7_hgt_reg  <= half_chord > COORD_W'(c2_side.overlap);
            s7_prod_reg <= 48'(half_chord - COORD_W'(c2_side.overlap)) * 48'(c2_side.frac);
        end
    end

    // ---------------- output register ----------------
    logic [RAD_W-1:0] radius_c;

    always_comb
    begin
        unique case (s7_reg.code)
            CASE_CROSS:
                radius_c = s7_hgt_reg
                         ? RAD_W'(COORD_W'(s7_reg.overlap) + s7_prod_reg[47:PICK_W])
                         : s7_reg.overlap;
            CASE_DISJOINT:
                radius_c = '0;
            default:
                radius_c = s7_reg.rsel;
        endcase
    end

    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [RAD_W-1:0]   out_r_reg;
    case_t              out_code_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg    <= s7_reg.mx;
            out_y_reg    <= s7_reg.my;
            out_r_reg    <= radius_c;
            out_code_reg <= s7_reg.code;
        end
    end

    // valid bits of the plain stages; the cells keep their own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            s4_valid_reg  <= sq1_bus[SQ_STEPS].valid;
            s5_valid_reg  <= dv_bus[DIV_STEPS].valid;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= sq2_bus[SQ_STEPS].valid;
            out_valid_reg <= s7_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_r_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_code_reg;

endmodule
